### src/gpse_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the grayscale PNG stored-stream encoder.
// No dependencies; every other file but gpse_checker imports this package.
package gpse_pkg;

    localparam int PIX_W    = 8;
    localparam int DIM_W    = 15;
    localparam int CNT_W    = 14;
    localparam int RAW_W    = 29;
    localparam int BLKS_W   = 13;
    localparam int IDX_W    = 6;
    localparam logic [DIM_W-1:0] MAX_DIM   = 15'd16384;
    localparam logic [DIM_W-1:0] MIN_WIDTH = 15'd2;
    localparam logic [DIM_W-1:0] MIN_HEIGHT = 15'd1;
    localparam logic [16:0] BLOCK_BYTES = 17'd65535;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [IDX_W-1:0] HDR_LAST = 6'd42;
    localparam logic [IDX_W-1:0] BLK_LAST = 6'd4;
    localparam logic [IDX_W-1:0] TRL_LAST = 6'd19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_BLK,
        ST_RAW,
        ST_TRL
    } state_t;

    typedef struct packed {
        logic             en;
        logic             init;
        logic [PIX_W-1:0] data;
    } crc_ctl_t;

    typedef struct packed {
        logic             en;
        logic             init;
        logic [PIX_W-1:0] data;
    } adler_ctl_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/gpse_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, file byte output, register writes.
// Depends on gpse_pkg for the field widths.
interface gpse_pixel_if import gpse_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface gpse_byte_if import gpse_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_byte;
    logic             last_of_run;
    logic             end_of_file;
    modport source (output valid, output out_byte, output last_of_run, output end_of_file,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input end_of_file,
                  output ready);
endinterface

interface gpse_cfg_if import gpse_pkg::*;;
    logic             valid;
    logic             ready;
    logic             addr;
    logic [DIM_W-1:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

### src/gpse_crc32.sv
`timescale 1ns / 1ps
// Byte-wide CRC-32 register shared by every chunk of the file.
// Depends on gpse_pkg.
module gpse_crc32 import gpse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctl_t    ctl,
    output logic [31:0] crc
);
    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.en)
        begin
            crc_next = crc_byte(ctl.init ? 32'hFFFFFFFF : crc_reg, ctl.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= 32'hFFFFFFFF;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;
endmodule

### src/gpse_adler.sv
`timescale 1ns / 1ps
// Adler-32 running sums over the raw stream, one byte per update.
// Depends on gpse_pkg.
module gpse_adler import gpse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  adler_ctl_t  ctl,
    output logic [31:0] sum
);
    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [16:0] a_sum, b_sum;

    always_comb
    begin
        a_sum  = {1'b0, a_reg} + {9'd0, ctl.data};
        a_next = (a_sum >= ADLER_MOD) ? 16'(a_sum - ADLER_MOD) : a_sum[15:0];
        b_sum  = {1'b0, b_reg} + {1'b0, a_next};
        b_next = (b_sum >= ADLER_MOD) ? 16'(b_sum - ADLER_MOD) : b_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 16'd1;
            b_reg <= 16'd0;
        end
        else if (ctl.init)
        begin
            a_reg <= 16'd1;
            b_reg <= 16'd0;
        end
        else if (ctl.en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign sum = {b_reg, a_reg};
endmodule

### src/gray_png_stored_stream_encoder_core.sv
`timescale 1ns / 1ps
// Top level: pixel items in, PNG file bytes out; each output byte is registered.
// An item causes 1 or 2 bytes, 5 more per block header, 43 more on the first pixel and 20 more
// on the last; a new pixel is taken only in the idle state, once the item's last byte is registered.
// A stalled output byte holds the item until the byte is taken.
// Reset (asynchronous, active low) sets width 2, height 1 and the next pixel starts a file.
// Depends on gpse_pkg, gpse_if, gpse_crc32 and gpse_adler.
module gray_png_stored_stream_encoder_core import gpse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    gpse_pixel_if.sink   pixel_in,
    gpse_byte_if.source  byte_out,
    gpse_cfg_if.sink     cfg
);
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic               filt_reg, filt_next;
    logic               hdr_sent_reg, hdr_sent_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [15:0]        blk_left_reg, blk_left_next;
    logic [RAW_W-1:0]   raw_left_reg, raw_left_next;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [RAW_W-1:0]   raw_reg;
    logic [BLKS_W-1:0]  blocks_reg;
    logic [RAW_W-1:0]   idat_reg;
    logic               ov_reg, ov_next;
    logic [PIX_W-1:0]   ob_reg, ob_next;
    logic               ol_reg, ol_next;
    logic               oe_reg, oe_next;

    crc_ctl_t    crc_ctl;
    adler_ctl_t  adler_ctl;
    logic [31:0] crc;
    logic [31:0] adler;
    logic [31:0] crcx;
    logic [31:0] idat32;
    logic        adv;
    logic        accept;
    logic        cfg_wr;
    logic        stream_clr;
    logic [7:0]  byte_val;
    logic [15:0] blk_n;
    logic        blk_final;
    logic [15:0] blk_after;
    logic        row_end;
    logic        img_end;
    logic [DIM_W-1:0] cfg_clamped;
    logic [12:0] q0;
    logic [16:0] rsum;
    logic        radj;
    logic [16:0] rrem;

    gpse_crc32 u_crc (.clk(clk), .rst_n(rst_n), .ctl(crc_ctl), .crc(crc));
    gpse_adler u_adler (.clk(clk), .rst_n(rst_n), .ctl(adler_ctl), .sum(adler));

    assign accept = pixel_in.valid && pixel_in.ready;
    assign cfg_wr = cfg.valid && cfg.ready;
    assign adv    = (state_reg != ST_IDLE) && (!ov_reg || byte_out.ready);
    assign crcx   = ~crc;
    assign idat32 = {3'd0, idat_reg};

    assign pixel_in.ready       = (state_reg == ST_IDLE);
    assign cfg.ready            = 1'b1;
    assign byte_out.valid       = ov_reg;
    assign byte_out.out_byte    = ob_reg;
    assign byte_out.last_of_run = ol_reg;
    assign byte_out.end_of_file = oe_reg;

    always_comb
    begin
        cfg_clamped = cfg.data;
        if (cfg.addr == REG_WIDTH)
        begin
            if (cfg.data < MIN_WIDTH)
            begin
                cfg_clamped = MIN_WIDTH;
            end
        end
        else if (cfg.data < MIN_HEIGHT)
        begin
            cfg_clamped = MIN_HEIGHT;
        end
        if (cfg.data > MAX_DIM)
        begin
            cfg_clamped = MAX_DIM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= MIN_WIDTH;
            height_reg <= MIN_HEIGHT;
        end
        else if (cfg_wr)
        begin
            if (cfg.addr == REG_WIDTH)
            begin
                width_reg <= cfg_clamped;
            end
            else
            begin
                height_reg <= cfg_clamped;
            end
        end
    end

    // The IDAT length is derived in three registered steps from the configured size.
    always_comb
    begin
        q0   = raw_reg[RAW_W-1:16];
        rsum = {1'b0, raw_reg[15:0]} + {4'd0, q0};
        radj = (rsum >= BLOCK_BYTES);
        rrem = radj ? (rsum - BLOCK_BYTES) : rsum;
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= RAW_W'({14'd0, height_reg} * {14'd0, 15'(width_reg + 15'd1)});
        blocks_reg <= q0 + {12'd0, radj} + {12'd0, (rrem != 17'd0)};
        idat_reg   <= raw_reg + {14'd0, blocks_reg, 2'd0} + {16'd0, blocks_reg} + RAW_W'(6);
    end

    always_comb
    begin
        blk_final = (raw_left_reg <= RAW_W'(BLOCK_BYTES));
        blk_n     = blk_final ? raw_left_reg[15:0] : BLOCK_BYTES[15:0];
        blk_after = (blk_left_reg != 16'd0) ? (blk_left_reg - 16'd1) : 16'd0;
        row_end   = ({1'b0, col_reg} + 15'd1) >= width_reg;
        img_end   = row_end && (({1'b0, row_reg} + 15'd1) >= height_reg);
    end

    always_comb
    begin
        byte_val = 8'd0;
        case (state_reg)
            ST_HDR:
            begin
                case (idx_reg)
                    6'd0:  byte_val = 8'h89;
                    6'd1:  byte_val = 8'h50;
                    6'd2:  byte_val = 8'h4E;
                    6'd3:  byte_val = 8'h47;
                    6'd4:  byte_val = 8'h0D;
                    6'd5:  byte_val = 8'h0A;
                    6'd6:  byte_val = 8'h1A;
                    6'd7:  byte_val = 8'h0A;
                    6'd11: byte_val = 8'd13;
                    6'd12: byte_val = 8'h49;
                    6'd13: byte_val = 8'h48;
                    6'd14: byte_val = 8'h44;
                    6'd15: byte_val = 8'h52;
                    6'd18: byte_val = {1'b0, width_reg[14:8]};
                    6'd19: byte_val = width_reg[7:0];
                    6'd22: byte_val = {1'b0, height_reg[14:8]};
                    6'd23: byte_val = height_reg[7:0];
                    6'd24: byte_val = 8'd8;
                    6'd29: byte_val = crcx[31:24];
                    6'd30: byte_val = crcx[23:16];
                    6'd31: byte_val = crcx[15:8];
                    6'd32: byte_val = crcx[7:0];
                    6'd33: byte_val = idat32[31:24];
                    6'd34: byte_val = idat32[23:16];
                    6'd35: byte_val = idat32[15:8];
                    6'd36: byte_val = idat32[7:0];
                    6'd37: byte_val = 8'h49;
                    6'd38: byte_val = 8'h44;
                    6'd39: byte_val = 8'h41;
                    6'd40: byte_val = 8'h54;
                    6'd41: byte_val = 8'h78;
                    6'd42: byte_val = 8'h01;
                    default: byte_val = 8'd0;
                endcase
            end
            ST_BLK:
            begin
                case (idx_reg)
                    6'd0:    byte_val = {7'd0, blk_final};
                    6'd1:    byte_val = blk_n[7:0];
                    6'd2:    byte_val = blk_n[15:8];
                    6'd3:    byte_val = ~blk_n[7:0];
                    6'd4:    byte_val = ~blk_n[15:8];
                    default: byte_val = 8'd0;
                endcase
            end
            ST_RAW:
            begin
                byte_val = filt_reg ? 8'd0 : pix_reg;
            end
            ST_TRL:
            begin
                case (idx_reg)
                    6'd0:  byte_val = adler[31:24];
                    6'd1:  byte_val = adler[23:16];
                    6'd2:  byte_val = adler[15:8];
                    6'd3:  byte_val = adler[7:0];
                    6'd4:  byte_val = crcx[31:24];
                    6'd5:  byte_val = crcx[23:16];
                    6'd6:  byte_val = crcx[15:8];
                    6'd7:  byte_val = crcx[7:0];
                    6'd12: byte_val = 8'h49;
                    6'd13: byte_val = 8'h45;
                    6'd14: byte_val = 8'h4E;
                    6'd15: byte_val = 8'h44;
                    6'd16: byte_val = crcx[31:24];
                    6'd17: byte_val = crcx[23:16];
                    6'd18: byte_val = crcx[15:8];
                    6'd19: byte_val = crcx[7:0];
                    default: byte_val = 8'd0;
                endcase
            end
            default: byte_val = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pix_next      = pix_reg;
        filt_next     = filt_reg;
        hdr_sent_next = hdr_sent_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        blk_left_next = blk_left_reg;
        raw_left_next = raw_left_reg;
        stream_clr    = 1'b0;
        ov_next       = byte_out.ready ? 1'b0 : ov_reg;
        ob_next       = ob_reg;
        ol_next       = ol_reg;
        oe_next       = oe_reg;
        crc_ctl       = '{en: 1'b0, init: 1'b0, data: byte_val};
        adler_ctl     = '{en: 1'b0, init: 1'b0, data: byte_val};

        if (adv)
        begin
            ov_next = 1'b1;
            ob_next = byte_val;
            ol_next = 1'b0;
            oe_next = 1'b0;
            idx_next = idx_reg + 6'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pix_next  = pixel_in.pixel;
                    filt_next = (col_reg == '0);
                    idx_next  = '0;
                    if (!hdr_sent_reg)
                    begin
                        state_next = ST_HDR;
                    end
                    else if (blk_left_reg == 16'd0)
                    begin
                        state_next = ST_BLK;
                    end
                    else
                    begin
                        state_next = ST_RAW;
                    end
                end
            end
            ST_HDR:
            begin
                if (adv)
                begin
                    crc_ctl.en   = ((idx_reg >= 6'd12) && (idx_reg <= 6'd28)) ||
                                   (idx_reg >= 6'd37);
                    crc_ctl.init = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                    if (idx_reg == HDR_LAST)
                    begin
                        raw_left_next  = raw_reg;
                        blk_left_next  = 16'd0;
                        adler_ctl.init = 1'b1;
                        col_next       = '0;
                        row_next       = '0;
                        hdr_sent_next  = 1'b1;
                        filt_next      = 1'b1;
                        idx_next       = '0;
                        state_next     = ST_BLK;
                    end
                end
            end
            ST_BLK:
            begin
                if (adv)
                begin
                    crc_ctl.en = 1'b1;
                    if (idx_reg == BLK_LAST)
                    begin
                        blk_left_next = blk_n;
                        idx_next      = '0;
                        state_next    = ST_RAW;
                    end
                end
            end
            ST_RAW:
            begin
                if (adv)
                begin
                    crc_ctl.en   = 1'b1;
                    adler_ctl.en = 1'b1;
                    blk_left_next = blk_after;
                    if (raw_left_reg != '0)
                    begin
                        raw_left_next = raw_left_reg - RAW_W'(1);
                    end
                    idx_next = '0;
                    if (filt_reg)
                    begin
                        filt_next  = 1'b0;
                        state_next = (blk_after == 16'd0) ? ST_BLK : ST_RAW;
                    end
                    else if (img_end)
                    begin
                        col_next   = '0;
                        row_next   = row_reg + CNT_W'(1);
                        state_next = ST_TRL;
                    end
                    else
                    begin
                        ol_next = 1'b1;
                        if (row_end)
                        begin
                            col_next = '0;
                            row_next = row_reg + CNT_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + CNT_W'(1);
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TRL:
            begin
                if (adv)
                begin
                    crc_ctl.en   = (idx_reg <= 6'd3) ||
                                   ((idx_reg >= 6'd12) && (idx_reg <= 6'd15));
                    crc_ctl.init = (idx_reg == 6'd12);
                    if (idx_reg == TRL_LAST)
                    begin
                        ol_next    = 1'b1;
                        oe_next    = 1'b1;
                        stream_clr = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            stream_clr = 1'b1;
        end
        if (stream_clr)
        begin
            hdr_sent_next  = 1'b0;
            col_next       = '0;
            row_next       = '0;
            blk_left_next  = 16'd0;
            raw_left_next  = '0;
            adler_ctl.init = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            filt_reg     <= 1'b0;
            hdr_sent_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            blk_left_reg <= 16'd0;
            raw_left_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            filt_reg     <= filt_next;
            hdr_sent_reg <= hdr_sent_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            blk_left_reg <= blk_left_next;
            raw_left_reg <= raw_left_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
        oe_reg  <= oe_next;
    end
endmodule

### src/gpse_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the encoder top level, attached by bind.
// Depends on gray_png_stored_stream_encoder_core.
module gpse_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [7:0] out_byte,
    input logic out_last,
    input logic out_eof
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output item dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte))
        else $error("Output byte changed while stalled.");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_eof |-> out_last)
        else $error("End of file without end of run.");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Pixel taken while the previous one is at work.");
endmodule

bind gray_png_stored_stream_encoder_core gpse_checker u_gpse_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(pixel_in.valid),
    .in_ready(pixel_in.ready),
    .out_valid(byte_out.valid),
    .out_ready(byte_out.ready),
    .out_byte(byte_out.out_byte),
    .out_last(byte_out.last_of_run),
    .out_eof(byte_out.end_of_file)
);

### tb/tb_gray_png_stored_stream_encoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench of gray_png_stored_stream_encoder_core: pixels go in, and
// every PNG file byte that comes out is checked against a byte-exact encoder model.
// Depends on gpse_pkg, the gpse_if interfaces and the core.
module tb_gray_png_stored_stream_encoder_core;
    import gpse_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } file_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gpse_pixel_if pixel_ch ();
    gpse_byte_if  byte_ch ();
    gpse_cfg_if   cfg_ch ();

    gray_png_stored_stream_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_ch.sink),
        .byte_out (byte_ch.source),
        .cfg      (cfg_ch.sink)
    );

    always #5 clk = ~clk;

    logic [7:0]  pixel_q[$];
    file_byte_t  png_bytes_q[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_pixels = 1'b0;
    int          errors = 0;
    int          pixels_sent = 0;
    int          bytes_checked = 0;
    int          files_done = 0;

    // Encoder model state.
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
    logic [31:0]      crc_acc;
    logic [15:0]      adler_a;
    logic [15:0]      adler_b;
    logic [DIM_W-1:0] col_cnt;
    logic [DIM_W-1:0] row_cnt;
    logic [16:0]      blk_left;
    logic [RAW_W-1:0] raw_left;
    bit               hdr_done;

    task automatic clear_stream();
        crc_acc  = '1;
        adler_a  = 16'd1;
        adler_b  = 16'd0;
        col_cnt  = '0;
        row_cnt  = '0;
        blk_left = '0;
        raw_left = '0;
        hdr_done = 1'b0;
    endtask

    task automatic emit(input logic [7:0] b, input bit in_crc);
        file_byte_t fb;
        logic [31:0] c;
        if (in_crc)
        begin
            c = crc_acc ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
            end
            crc_acc = c;
        end
        fb.data = b;
        fb.last = 1'b0;
        fb.eof  = 1'b0;
        png_bytes_q = {png_bytes_q, fb};
    endtask

    task automatic emit_word(input logic [31:0] x, input bit in_crc);
        for (int s = 24; s >= 0; s -= 8)
        begin
            emit(x[s +: 8], in_crc);
        end
    endtask

    task automatic emit_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            emit(s[i], 1'b1);
        end
    endtask

    task automatic emit_file_head();
        longint raw_len;
        longint nblk;
        raw_len = longint'(img_h) * (longint'(img_w) + 1);
        nblk = (raw_len + 65534) / 65535;
        emit(8'h89, 0); emit("P", 0); emit("N", 0); emit("G", 0);
        emit(8'h0D, 0); emit(8'h0A, 0); emit(8'h1A, 0); emit(8'h0A, 0);
        emit_word(32'd13, 0);
        crc_acc = '1;
        emit_str("IHDR");
        emit_word(32'(img_w), 1);
        emit_word(32'(img_h), 1);
        emit(8'd8, 1); emit(8'd0, 1); emit(8'd0, 1); emit(8'd0, 1); emit(8'd0, 1);
        emit_word(crc_acc ^ 32'hFFFFFFFF, 0);
        emit_word(32'(2 + raw_len + 5 * nblk + 4), 0);
        crc_acc = '1;
        emit_str("IDAT");
        emit(8'h78, 1); emit(8'h01, 1);
        raw_left = RAW_W'(raw_len);
        blk_left = '0;
        adler_a  = 16'd1;
        adler_b  = 16'd0;
        col_cnt  = '0;
        row_cnt  = '0;
        hdr_done = 1'b1;
    endtask

    task automatic emit_raw(input logic [7:0] v);
        logic [15:0] n;
        logic        fin;
        logic [16:0] sum;
        if (blk_left == 0)
        begin
            fin = (raw_left <= 65535);
            n = fin ? raw_left[15:0] : 16'hFFFF;
            emit({7'd0, fin}, 1);
            emit(n[7:0], 1); emit(n[15:8], 1);
            emit(~n[7:0], 1); emit(~n[15:8], 1);
            blk_left = {1'b0, n};
        end
        emit(v, 1);
        sum = adler_a + v;
        if (sum >= 65521) sum -= 65521;
        adler_a = sum[15:0];
        sum = adler_b + adler_a;
        if (sum >= 65521) sum -= 65521;
        adler_b = sum[15:0];
        if (blk_left > 0) blk_left--;
        if (raw_left > 0) raw_left--;
    endtask

    task automatic predict_pixel(input logic [7:0] v);
        bit done;
        done = 1'b0;
        if (!hdr_done) emit_file_head();
        if (col_cnt == 0) emit_raw(8'd0);
        emit_raw(v);
        col_cnt++;
        if (col_cnt >= img_w)
        begin
            col_cnt = '0;
            row_cnt++;
            if (row_cnt >= img_h)
            begin
                emit_word({adler_b, adler_a}, 1);
                emit_word(crc_acc ^ 32'hFFFFFFFF, 0);
                emit_word(32'd0, 0);
                crc_acc = '1;
                emit_str("IEND");
                emit_word(crc_acc ^ 32'hFFFFFFFF, 0);
                done = 1'b1;
            end
        end
        png_bytes_q[png_bytes_q.size() - 1].last = 1'b1;
        if (done)
        begin
            png_bytes_q[png_bytes_q.size() - 1].eof = 1'b1;
            clear_stream();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid <= 1'b0;
            pixel_ch.pixel <= '0;
        end
        else if (!pixel_ch.valid || pixel_ch.ready)
        begin
            if (pixel_q.size() > 0 && !hold_pixels && $urandom_range(99) >= send_idle_pct)
            begin
                pixel_ch.valid <= 1'b1;
                pixel_ch.pixel <= pixel_q.pop_front();
            end
            else
            begin
                pixel_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_ch.ready <= 1'b0;
        else
            byte_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        file_byte_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            predict_pixel(pixel_ch.pixel);
            pixels_sent++;
        end
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (png_bytes_q.size() == 0)
            begin
                $display("%0t: unexpected byte %h", $time, byte_ch.out_byte);
                errors++;
            end
            else
            begin
                want = png_bytes_q.pop_front();
                bytes_checked++;
                if (byte_ch.end_of_file) files_done++;
                if (byte_ch.out_byte !== want.data || byte_ch.last_of_run !== want.last
                    || byte_ch.end_of_file !== want.eof)
                begin
                    $display("%0t: expected byte %h last %b eof %b, got %h last %b eof %b",
                             $time, want.data, want.last, want.eof, byte_ch.out_byte,
                             byte_ch.last_of_run, byte_ch.end_of_file);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pixel_q.size() > 0 || pixel_ch.valid || png_bytes_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] value);
        logic [DIM_W-1:0] v;
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        v = value;
        if (idx == REG_WIDTH)
        begin
            if (v < 2) v = 2;
            if (v > 16384) v = 16384;
            img_w = v;
        end
        else
        begin
            if (v < 1) v = 1;
            if (v > 16384) v = 16384;
            img_h = v;
        end
        clear_stream();
        @(posedge clk);
    endtask

    task automatic run_image(input int w, input int h, input int npix);
        wait_drained();
        write_reg(REG_WIDTH, DIM_W'(w));
        write_reg(REG_HEIGHT, DIM_W'(h));
        for (int i = 0; i < npix; i++)
            pixel_q = {pixel_q, 8'($urandom)};
        wait_drained();
    endtask

    initial
    begin
        int w;
        int h;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr  = REG_WIDTH;
        cfg_ch.data  = '0;
        img_w = 2;
        img_h = 1;
        clear_stream();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size, two files back to back, extreme pixel values, then clamped and extreme sizes.
        pixel_q = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        wait_drained();
        run_image(0, 0, 2);
        run_image(1, 2, 4);
        run_image(16384, 1, 3);
        run_image(32767, 32767, 2);
        run_image(3, 16384, 4);
        run_image(16383, 2, 2);

        // The sender pauses until every byte has come out, then the file is aborted.
        write_reg(REG_WIDTH, 15'd3);
        write_reg(REG_HEIGHT, 15'd2);
        pixel_q = '{8'h01, 8'h80};
        while (pixel_q.size() > 0 || pixel_ch.valid) @(posedge clk);
        hold_pixels = 1'b1;
        pixel_q = {pixel_q, 8'h7F};
        while (png_bytes_q.size() > 0) @(posedge clk);
        repeat (3) @(posedge clk);
        hold_pixels = 1'b0;
        run_image(3, 2, 8);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 51 : 0;
            recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 30 : 0;
            for (int n = 0; n < 6; n++)
            begin
                w = $urandom_range(6, 2);
                h = $urandom_range(4, 1);
                if ($urandom_range(3) == 0)
                    run_image(w, h, $urandom_range(w * h - 1, 1));
                else
                    run_image(w, h, w * h * $urandom_range(2, 1));
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);
        $display("Sent %0d pixels, checked %0d file bytes, %0d complete files.",
                 pixels_sent, bytes_checked, files_done);
        $display("Sizes ranged from clamped extremes down to 2x1, with mid-file rewrites.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Timeout with %0d bytes outstanding.", png_bytes_q.size());
        $display("status: fail");
        $finish;
    end

endmodule
